/* design/tcte_pkg.sv */
`default_nettype none

package tcte_pkg;

    // Field widths of the item channels
    localparam int COORD_W  = 12;
    localparam int CHAR_W   = 8;
    localparam int COLOUR_W = 16;
    localparam int VAL_W    = 7;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 64;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;

    localparam logic [COLOUR_W-1:0] DEFAULT_FG_RST = 16'h0000;
    localparam logic [COLOUR_W-1:0] BACKGROUND_RST = 16'hffff;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0b;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LBR   = 8'h5b;
    localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5c;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h6d;

    localparam logic [VAL_W-1:0] VAL_MAX       = 7'd99;
    localparam logic [VAL_W-1:0] VAL_COLOUR_LO = 7'd30;
    localparam logic [VAL_W-1:0] VAL_COLOUR_HI = 7'd37;
    localparam logic [VAL_W-1:0] VAL_RESTORE   = 7'd0;

    localparam logic [COLOUR_W-1:0] COLOUR_TABLE [8] = '{
        16'h001f, 16'h07e0, 16'hf800, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BSL,
        PH_E,
        PH_DIG
    } esc_phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_MOVE,
        ACT_GLYPH,
        ACT_PUSH,
        ACT_COLOUR,
        ACT_BREAK
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_BRK_FLUSH,
        ST_EOT_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic feed_exec;
        logic flush_emit;
        logic flush_done;
        logic push_last;
    } cmd_t;

    typedef struct packed {
        logic act_break;
        logic act_glyph;
        logic emit_ok;
        logic out_free;
        logic stg_valid;
        logic flush_last;
        logic eot_flush;
    } sts_t;

    function automatic logic [COLOUR_W-1:0] colour_lookup(input logic [2:0] idx);
        return COLOUR_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

/* design/tcte_ctrl.sv */
`default_nettype none

module tcte_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire tcte_pkg::sts_t sts,
    output tcte_pkg::cmd_t     cmd
);

    tcte_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcte_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Last glyph of the previous item leaves the staging slot while the next item enters
    assign s_tready = (state_reg == tcte_pkg::ST_IDLE) && (!sts.stg_valid || sts.out_free);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcte_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = tcte_pkg::ST_FEED;
                end
            end
            tcte_pkg::ST_FEED: begin
                if (sts.act_break) begin
                    state_next = tcte_pkg::ST_BRK_FLUSH;
                end else if (!sts.act_glyph || sts.emit_ok) begin
                    state_next = sts.eot_flush ? tcte_pkg::ST_EOT_FLUSH : tcte_pkg::ST_IDLE;
                end
            end
            tcte_pkg::ST_BRK_FLUSH: begin
                if (sts.emit_ok && sts.flush_last) begin
                    state_next = tcte_pkg::ST_FEED;
                end
            end
            tcte_pkg::ST_EOT_FLUSH: begin
                if (sts.emit_ok && sts.flush_last) begin
                    state_next = tcte_pkg::ST_IDLE;
                end
            end
            default: state_next = tcte_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            tcte_pkg::ST_IDLE: begin
                cmd.push_last = sts.stg_valid && sts.out_free;
                cmd.load      = s_tvalid && s_tready;
            end
            tcte_pkg::ST_FEED: begin
                cmd.feed_exec = !sts.act_break && (!sts.act_glyph || sts.emit_ok);
            end
            tcte_pkg::ST_BRK_FLUSH, tcte_pkg::ST_EOT_FLUSH: begin
                cmd.flush_emit = sts.emit_ok;
                cmd.flush_done = sts.emit_ok && sts.flush_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* design/tcte_dp.sv */
`default_nettype none

module tcte_dp #(
    parameter int PEND_DEPTH = 8,
    parameter int TAB_STOP   = 5
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [tcte_pkg::IN_W-1:0]         s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    input  wire logic                              cfg_valid,
    input  wire logic [tcte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tcte_pkg::COLOUR_W-1:0]     cfg_data,
    input  wire logic                              m_tready,
    input  wire tcte_pkg::cmd_t                    cmd,
    output tcte_pkg::sts_t                         sts,
    output logic                                   m_tvalid,
    output logic [tcte_pkg::OUT_W-1:0]             m_tdata,
    output logic                                   m_tlast
);

    localparam int IDX_W = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int CNT_W = $clog2(PEND_DEPTH + 1);
    localparam int TAB_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int CW    = tcte_pkg::COORD_W;
    localparam int HW    = tcte_pkg::CHAR_W;
    localparam int FW    = tcte_pkg::COLOUR_W;
    localparam int VW    = tcte_pkg::VAL_W;

    typedef struct packed {
        logic [FW-1:0] bg;
        logic [FW-1:0] fg;
        logic [CW-1:0] row;
        logic [CW-1:0] col;
        logic [HW-1:0] glyph;
    } glyph_t;

    // Item and cursor state
    logic [HW-1:0]        ch_reg,      ch_next;
    logic                 eot_reg,     eot_next;
    logic [CW-1:0]        col_reg,     col_next;
    logic [CW-1:0]        row_reg,     row_next;
    logic [FW-1:0]        fg_reg,      fg_next;
    logic [TAB_W-1:0]     tab_reg,     tab_next;
    tcte_pkg::esc_phase_t phase_reg,   phase_next;
    logic [VW-1:0]        val_reg,     val_next;
    logic                 hd_reg,      hd_next;
    logic [CNT_W-1:0]     cnt_reg,     cnt_next;
    logic [IDX_W-1:0]     idx_reg,     idx_next;
    logic [FW-1:0]        def_fg_reg,  def_fg_next;
    logic [FW-1:0]        bg_reg,      bg_next;
    logic                 stg_vld_reg, stg_vld_next;
    glyph_t               stg_reg,     stg_next;
    logic                 m_vld_reg,   m_vld_next;
    glyph_t               out_reg,     out_next;
    logic                 last_reg,    last_next;

    logic [HW-1:0] pend_reg [PEND_DEPTH];
    logic          pend_we;
    logic [IDX_W-1:0] pend_wa;

    tcte_pkg::act_t       act;
    tcte_pkg::esc_phase_t push_phase;
    tcte_pkg::esc_phase_t phase_after;
    logic                 is_digit;
    logic                 cnt_room;
    logic                 val_colour;
    logic [9:0]           val_wide;
    logic [VW-1:0]        val_sat;
    logic [VW-1:0]        val_off;
    logic [CW-1:0]        tab_step;
    logic                 emit_en;
    logic                 emit_ok;
    logic [HW-1:0]        emit_ch;
    logic [CNT_W-1:0]     push_base;

    assign is_digit   = (ch_reg >= tcte_pkg::CH_ZERO) && (ch_reg <= tcte_pkg::CH_NINE);
    assign cnt_room   = cnt_reg < CNT_W'(PEND_DEPTH);
    assign val_colour = (val_reg >= tcte_pkg::VAL_COLOUR_LO) &&
                        (val_reg <= tcte_pkg::VAL_COLOUR_HI);
    // value*10 + digit, as two shifts and adds
    assign val_wide   = {val_reg, 3'b000} + {2'b00, val_reg, 1'b0} +
                        {6'd0, ch_reg[3:0]};
    assign val_sat    = (val_wide > {3'd0, tcte_pkg::VAL_MAX}) ? tcte_pkg::VAL_MAX
                                                               : val_wide[VW-1:0];
    assign val_off    = val_reg - tcte_pkg::VAL_COLOUR_LO;
    assign tab_step   = CW'(TAB_STOP) - CW'(tab_reg);

    // What the held character does in the current escape phase
    always_comb begin
        act        = tcte_pkg::ACT_NONE;
        push_phase = tcte_pkg::PH_IDLE;
        if (ch_reg != tcte_pkg::CH_NUL) begin
            unique case (phase_reg)
                tcte_pkg::PH_IDLE: begin
                    if (ch_reg == tcte_pkg::CH_SPACE || ch_reg == tcte_pkg::CH_NL ||
                        ch_reg == tcte_pkg::CH_BS || ch_reg == tcte_pkg::CH_VT ||
                        ch_reg == tcte_pkg::CH_CR || ch_reg == tcte_pkg::CH_TAB) begin
                        act = tcte_pkg::ACT_MOVE;
                    end else if (ch_reg == tcte_pkg::CH_BSL) begin
                        act        = tcte_pkg::ACT_PUSH;
                        push_phase = tcte_pkg::PH_BSL;
                    end else begin
                        act = tcte_pkg::ACT_GLYPH;
                    end
                end
                tcte_pkg::PH_BSL: begin
                    act        = (ch_reg == tcte_pkg::CH_E) ? tcte_pkg::ACT_PUSH
                                                            : tcte_pkg::ACT_BREAK;
                    push_phase = tcte_pkg::PH_E;
                end
                tcte_pkg::PH_E: begin
                    act        = (ch_reg == tcte_pkg::CH_LBR) ? tcte_pkg::ACT_PUSH
                                                              : tcte_pkg::ACT_BREAK;
                    push_phase = tcte_pkg::PH_DIG;
                end
                tcte_pkg::PH_DIG: begin
                    push_phase = tcte_pkg::PH_DIG;
                    priority if (is_digit) begin
                        act = cnt_room ? tcte_pkg::ACT_PUSH : tcte_pkg::ACT_BREAK;
                    end else if (ch_reg == tcte_pkg::CH_M && hd_reg &&
                                 (val_reg == tcte_pkg::VAL_RESTORE || val_colour)) begin
                        act = tcte_pkg::ACT_COLOUR;
                    end else begin
                        act = tcte_pkg::ACT_BREAK;
                    end
                end
                default: act = tcte_pkg::ACT_NONE;
            endcase
        end
    end

    always_comb begin
        unique case (act)
            tcte_pkg::ACT_PUSH: phase_after = push_phase;
            tcte_pkg::ACT_NONE: phase_after = phase_reg;
            default:            phase_after = tcte_pkg::PH_IDLE;
        endcase
    end

    assign emit_ok = !stg_vld_reg || !m_vld_reg || m_tready;
    assign emit_en = (cmd.feed_exec && act == tcte_pkg::ACT_GLYPH) || cmd.flush_emit;
    assign emit_ch = cmd.flush_emit ? pend_reg[idx_reg] : ch_reg;
    assign push_base = (phase_reg == tcte_pkg::PH_IDLE) ? '0 : cnt_reg;
    assign pend_wa   = push_base[IDX_W-1:0];
    assign pend_we   = cmd.feed_exec && act == tcte_pkg::ACT_PUSH &&
                       push_base < CNT_W'(PEND_DEPTH);

    assign sts.act_break  = act == tcte_pkg::ACT_BREAK;
    assign sts.act_glyph  = act == tcte_pkg::ACT_GLYPH;
    assign sts.emit_ok    = emit_ok;
    assign sts.out_free   = !m_vld_reg || m_tready;
    assign sts.stg_valid  = stg_vld_reg;
    assign sts.flush_last = CNT_W'(idx_reg) == (cnt_reg - CNT_W'(1));
    assign sts.eot_flush  = eot_reg && phase_after != tcte_pkg::PH_IDLE;

    always_comb begin
        ch_next      = ch_reg;
        eot_next     = eot_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        fg_next      = fg_reg;
        tab_next     = tab_reg;
        phase_next   = phase_reg;
        val_next     = val_reg;
        hd_next      = hd_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        def_fg_next  = def_fg_reg;
        bg_next      = bg_reg;
        stg_vld_next = stg_vld_reg;
        stg_next     = stg_reg;
        m_vld_next   = m_vld_reg;
        out_next     = out_reg;
        last_next    = last_reg;

        if (cfg_valid) begin
            if (cfg_index == tcte_pkg::REG_DEFAULT_FG) begin
                def_fg_next = cfg_data;
            end else if (cfg_index == tcte_pkg::REG_BACKGROUND) begin
                bg_next = cfg_data;
            end
        end

        if (cmd.load) begin
            ch_next  = s_tdata[31:24];
            eot_next = s_tlast;
            if (s_tuser) begin
                col_next   = s_tdata[11:0];
                row_next   = s_tdata[23:12];
                fg_next    = def_fg_reg;
                tab_next   = '0;
                phase_next = tcte_pkg::PH_IDLE;
                val_next   = '0;
                hd_next    = 1'b0;
                cnt_next   = '0;
            end
        end

        if (cmd.feed_exec) begin
            unique case (act)
                tcte_pkg::ACT_MOVE: begin
                    unique case (ch_reg)
                        tcte_pkg::CH_SPACE: col_next = col_reg + CW'(1);
                        tcte_pkg::CH_NL: begin
                            col_next = '0;
                            row_next = row_reg + CW'(1);
                        end
                        tcte_pkg::CH_BS:  col_next = col_reg - CW'(1);
                        tcte_pkg::CH_VT:  row_next = row_reg - CW'(1);
                        tcte_pkg::CH_CR:  col_next = '0;
                        tcte_pkg::CH_TAB: col_next = col_reg + tab_step;
                        default:          col_next = col_reg;
                    endcase
                end
                tcte_pkg::ACT_PUSH: begin
                    phase_next = push_phase;
                    if (push_base < CNT_W'(PEND_DEPTH)) begin
                        cnt_next = push_base + CNT_W'(1);
                    end
                    if (phase_reg == tcte_pkg::PH_DIG) begin
                        val_next = val_sat;
                        hd_next  = 1'b1;
                    end else begin
                        val_next = '0;
                        hd_next  = 1'b0;
                    end
                end
                tcte_pkg::ACT_COLOUR: begin
                    fg_next    = (val_reg == tcte_pkg::VAL_RESTORE) ? def_fg_reg
                               : tcte_pkg::colour_lookup(val_off[2:0]);
                    phase_next = tcte_pkg::PH_IDLE;
                    val_next   = '0;
                    hd_next    = 1'b0;
                    cnt_next   = '0;
                end
                default: ;
            endcase
        end

        if (cmd.flush_emit) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.flush_done) begin
            idx_next   = '0;
            phase_next = tcte_pkg::PH_IDLE;
            val_next   = '0;
            hd_next    = 1'b0;
            cnt_next   = '0;
        end

        // One glyph is staged so the last of a run can be marked once the run is known
        priority if (emit_en && stg_vld_reg) begin
            out_next   = stg_reg;
            last_next  = 1'b0;
            m_vld_next = 1'b1;
        end else if (cmd.push_last) begin
            out_next   = stg_reg;
            last_next  = 1'b1;
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end else begin
            m_vld_next = m_vld_reg;
        end

        if (emit_en) begin
            stg_vld_next   = 1'b1;
            stg_next.glyph = emit_ch;
            stg_next.col   = col_reg;
            stg_next.row   = row_reg;
            stg_next.fg    = fg_reg;
            stg_next.bg    = bg_reg;
            col_next       = col_reg + CW'(1);
            tab_next       = (tab_reg == TAB_W'(TAB_STOP - 1)) ? '0 : tab_reg + TAB_W'(1);
        end else if (cmd.push_last) begin
            stg_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            fg_reg      <= tcte_pkg::DEFAULT_FG_RST;
            tab_reg     <= '0;
            phase_reg   <= tcte_pkg::PH_IDLE;
            val_reg     <= '0;
            hd_reg      <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            def_fg_reg  <= tcte_pkg::DEFAULT_FG_RST;
            bg_reg      <= tcte_pkg::BACKGROUND_RST;
            stg_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            fg_reg      <= fg_next;
            tab_reg     <= tab_next;
            phase_reg   <= phase_next;
            val_reg     <= val_next;
            hd_reg      <= hd_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            def_fg_reg  <= def_fg_next;
            bg_reg      <= bg_next;
            stg_vld_reg <= stg_vld_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg   <= ch_next;
        eot_reg  <= eot_next;
        stg_reg  <= stg_next;
        out_reg  <= out_next;
        last_reg <= last_next;
        if (pend_we) begin
            pend_reg[pend_wa] <= ch_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = last_reg;

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_en |-> emit_ok)
        else $error("glyph emitted while output and staging are both full");

    a_flush_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush_emit |-> cnt_reg != '0)
        else $error("flush with no pending characters");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(PEND_DEPTH))
        else $error("pending count beyond depth");

    a_open_seq_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != tcte_pkg::PH_IDLE |-> cnt_reg != '0)
        else $error("open sequence without pending characters");

    a_val_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        val_reg <= tcte_pkg::VAL_MAX)
        else $error("sequence value above saturation limit");

endmodule

`default_nettype wire

/* design/text_cell_terminal_engine.sv */
// Character-cell text terminal engine.
// s_ channel: one character item per handshake. s_tdata = {char_code[31:24],
//   start_row[23:12], start_col[11:0]}, s_tuser = start_req, s_tlast = end_of_text.
// m_ channel: one glyph draw item per handshake. m_tdata = {bg[63:48], fg[47:32],
//   row[31:20], col[19:8], glyph[7:0]}, m_tlast marks the final glyph of an input item.
// cfg_ channel: register writes (index 0 default_fg, 1 background), always ready;
//   write only while the engine is idle.
// Timing: an item is decoded the cycle after it is accepted, and a new item is accepted
//   only once the engine is back in its idle state. A glyph passes through the staging
//   register and then the output register before it reaches m_tvalid. A failed sequence
//   replays its pending characters (up to PEND_DEPTH) as glyphs and then decodes the
//   breaking character again; an end-of-text flush replays the pending characters. Both
//   replay from the pending buffer at one glyph per cycle while a glyph can be staged.
// Reset (aresetn low, synchronous) homes the cursor, drops any open sequence and
//   empties the output; registers return to default_fg 0, background 0xffff.
// A stalled m_tready holds the output item; the engine keeps one more glyph staged
//   and then waits, and s_tready stays low until the staged glyph can move on.
`default_nettype none

module text_cell_terminal_engine #(
    parameter int PEND_DEPTH = 8,
    parameter int TAB_STOP   = 5
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tcte_pkg::IN_W-1:0]       s_tdata,   // start_col, start_row, char_code
    input  wire logic                            s_tuser,   // start_req
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tcte_pkg::OUT_W-1:0]           m_tdata,   // glyph, col, row, fg, bg
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tcte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tcte_pkg::COLOUR_W-1:0]   cfg_data
);

    tcte_pkg::cmd_t cmd;
    tcte_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    tcte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcte_dp #(
        .PEND_DEPTH (PEND_DEPTH),
        .TAB_STOP   (TAB_STOP)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
